// ===== rtl/core/rc_stick_arm_gesture_decoder_top_macros.svh =====
// Assertion helpers for the stick gesture decoder.
`ifndef RC_STICK_ARM_GESTURE_DECODER_TOP_MACROS_SVH
`define RC_STICK_ARM_GESTURE_DECODER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define RCSAG_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define RCSAG_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RCSAG_ASSERT(name, clk, rst, prop, msg)

`define RCSAG_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// ===== rtl/core/rcsag_pkg.sv =====
package rcsag_pkg;

  typedef enum logic [1:0] {
    MODE_SAMPLE     = 2'd0,
    MODE_TICK       = 2'd1,
    MODE_CALIB_READ = 2'd2
  } mode_t;

  typedef enum logic {
    REG_GESTURE_DELAY = 1'b0,
    REG_REPEAT_HOLD   = 1'b1
  } reg_index_t;

  localparam logic [11:0] PULSE_MIN = 12'd1000;
  localparam logic [11:0] PULSE_MAX = 12'd2000;
  localparam logic [11:0] PULSE_MID = 12'd1500;
  localparam logic [9:0]  GESTURE_LEVEL = 10'd300;
  localparam logic [2:0]  LOST_LIMIT = 3'd3;
  localparam logic [15:0] GESTURE_DELAY_RESET = 16'd500;
  localparam logic [7:0]  REPEAT_HOLD_RESET = 8'd100;

  typedef struct packed {
    logic       active;
    logic [7:0] count;
    logic       restart;
    logic       fire;
  } gstep_t;

  function automatic logic pulse_ok(input logic [11:0] w);
    pulse_ok = (w >= PULSE_MIN) && (w <= PULSE_MAX);
  endfunction

  function automatic logic [9:0] stick_pos(input logic [11:0] w, input logic [11:0] offset);
    logic [12:0] diff;
    diff = {1'b0, w} - {1'b0, offset};
    stick_pos = pulse_ok(w) ? diff[9:0] : 10'd0;
  endfunction

  function automatic gstep_t gesture_step(input logic present, input logic active,
                                          input logic [7:0] count, input logic [7:0] hold,
                                          input logic delay_zero);
    gstep_t s;
    s = '{active: active, count: count, restart: 1'b0, fire: 1'b0};
    if (present) begin
      if (count == 8'd0) begin
        if (!active) begin
          s.active  = 1'b1;
          s.restart = 1'b1;
        end else if (delay_zero) begin
          s.count = hold;
          s.fire  = 1'b1;
        end
      end else begin
        s.count = hold;
      end
    end else begin
      s.active = 1'b0;
      if (count != 8'd0) begin
        s.count = count - 8'd1;
      end
    end
    gesture_step = s;
  endfunction

endpackage

// ===== rtl/core/rc_stick_arm_gesture_decoder_top.sv =====
// channel   direction  handshake                    payload
// sample    in         sample_valid / sample_stall  mode, four pulse widths
// result    out        result_valid / result_stall  four positions, armed, signal_lost,
//                                                   calibrate_request
// config    in         APB psel/penable/pwrite      gesture_delay_ms @0, repeat_hold_samples @4
//
// One word per cycle while result_stall is low; a word passes the input register,
// then the result register, on its way from acceptance to result.
// Reset is synchronous: config returns to 500 ms / 100 samples, loss is ignored
// until the first arm toggle, no words are held.
// A stalled result holds; one more word waits in the input register before
// sample_stall rises.
`include "rc_stick_arm_gesture_decoder_top_macros.svh"

module rc_stick_arm_gesture_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  logic [1:0]  mode,
  input  logic [11:0] throttle_pulse,
  input  logic [11:0] pitch_pulse,
  input  logic [11:0] roll_pulse,
  input  logic [11:0] yaw_pulse,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [9:0]  throttle_pos,
  output logic signed [9:0] pitch_pos,
  output logic signed [9:0] roll_pos,
  output logic signed [9:0] yaw_pos,
  output logic        armed,
  output logic        signal_lost,
  output logic        calibrate_request,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rcsag_pkg::*;

  logic [15:0] gesture_delay_ms;
  logic [7:0]  repeat_hold_samples;

  logic        stage_valid;
  logic [1:0]  stage_mode;
  logic [11:0] stage_throttle;
  logic [11:0] stage_pitch;
  logic [11:0] stage_roll;
  logic [11:0] stage_yaw;

  logic        armed_flag;
  logic        ignore_loss_flag;
  logic        arm_gesture_active;
  logic        calib_gesture_active;
  logic [7:0]  arm_repeat_count;
  logic [7:0]  calib_repeat_count;
  logic        calib_pending;
  logic [15:0] delay_remaining;

  logic        armed_flag_next;
  logic        ignore_loss_flag_next;
  logic        arm_gesture_active_next;
  logic        calib_gesture_active_next;
  logic [7:0]  arm_repeat_count_next;
  logic [7:0]  calib_repeat_count_next;
  logic        calib_pending_next;
  logic [15:0] delay_remaining_next;

  logic [9:0]  thr_next;
  logic signed [9:0] pit_next;
  logic signed [9:0] rol_next;
  logic signed [9:0] yaw_next;
  logic        lost_next;
  logic        calib_out_next;

  logic        advance;
  logic        cfg_write;
  logic [9:0]  thr_conv;
  logic signed [9:0] pit_conv;
  logic signed [9:0] rol_conv;
  logic signed [9:0] yaw_conv;
  logic [2:0]  lost_count;
  logic        base_g;
  logic        arm_g;
  logic        cal_g;
  logic [15:0] delay_mid;
  gstep_t      arm_s;
  gstep_t      cal_s;

  assign pready       = 1'b1;
  assign cfg_write    = psel && penable && pwrite && pready;
  assign advance      = stage_valid && (!result_valid || !result_stall);
  assign sample_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      gesture_delay_ms    <= GESTURE_DELAY_RESET;
      repeat_hold_samples <= REPEAT_HOLD_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(paddr[2]))
        REG_GESTURE_DELAY: gesture_delay_ms    <= pwdata[15:0];
        REG_REPEAT_HOLD:   repeat_hold_samples <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[2]))
      REG_GESTURE_DELAY: prdata = {16'd0, gesture_delay_ms};
      REG_REPEAT_HOLD:   prdata = {24'd0, repeat_hold_samples};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!sample_stall) begin
      stage_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      stage_mode     <= mode;
      stage_throttle <= throttle_pulse;
      stage_pitch    <= pitch_pulse;
      stage_roll     <= roll_pulse;
      stage_yaw      <= yaw_pulse;
    end
  end

  assign thr_conv = stick_pos(stage_throttle, PULSE_MIN);
  assign pit_conv = stick_pos(stage_pitch, PULSE_MID);
  assign rol_conv = stick_pos(stage_roll, PULSE_MID);
  assign yaw_conv = stick_pos(stage_yaw, PULSE_MID);

  assign lost_count = {2'd0, stage_throttle == 12'd0} + {2'd0, stage_pitch == 12'd0}
                    + {2'd0, stage_roll == 12'd0} + {2'd0, stage_yaw == 12'd0};

  assign base_g = (thr_conv < GESTURE_LEVEL) && (pit_conv < -$signed(GESTURE_LEVEL))
               && (rol_conv < -$signed(GESTURE_LEVEL));
  assign arm_g  = base_g && (yaw_conv > $signed(GESTURE_LEVEL));
  assign cal_g  = base_g && (yaw_conv < -$signed(GESTURE_LEVEL));

  assign arm_s = gesture_step(arm_g, arm_gesture_active, arm_repeat_count,
                              repeat_hold_samples, delay_remaining == 16'd0);
  assign delay_mid = arm_s.restart ? gesture_delay_ms : delay_remaining;
  assign cal_s = gesture_step(cal_g, calib_gesture_active, calib_repeat_count,
                              repeat_hold_samples, delay_mid == 16'd0);

  always_comb begin
    armed_flag_next           = armed_flag;
    ignore_loss_flag_next     = ignore_loss_flag;
    arm_gesture_active_next   = arm_gesture_active;
    calib_gesture_active_next = calib_gesture_active;
    arm_repeat_count_next     = arm_repeat_count;
    calib_repeat_count_next   = calib_repeat_count;
    calib_pending_next        = calib_pending;
    delay_remaining_next      = delay_remaining;
    thr_next       = 10'd0;
    pit_next       = 10'sd0;
    rol_next       = 10'sd0;
    yaw_next       = 10'sd0;
    lost_next      = 1'b0;
    calib_out_next = 1'b0;
    case (mode_t'(stage_mode))
      MODE_SAMPLE: begin
        if (lost_count >= LOST_LIMIT && !ignore_loss_flag) begin
          armed_flag_next = 1'b0;
          lost_next       = 1'b1;
        end else begin
          thr_next = thr_conv;
          pit_next = pit_conv;
          rol_next = rol_conv;
          yaw_next = yaw_conv;
          arm_gesture_active_next   = arm_s.active;
          arm_repeat_count_next     = arm_s.count;
          calib_gesture_active_next = cal_s.active;
          calib_repeat_count_next   = cal_s.count;
          delay_remaining_next      = cal_s.restart ? gesture_delay_ms : delay_mid;
          if (arm_s.fire) begin
            armed_flag_next       = !armed_flag;
            ignore_loss_flag_next = 1'b0;
          end
          if (cal_s.fire) begin
            calib_pending_next = 1'b1;
          end
        end
      end
      MODE_TICK: begin
        if (delay_remaining != 16'd0) begin
          delay_remaining_next = delay_remaining - 16'd1;
        end
      end
      MODE_CALIB_READ: begin
        calib_out_next     = calib_pending;
        calib_pending_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_flag           <= 1'b0;
      ignore_loss_flag     <= 1'b1;
      arm_gesture_active   <= 1'b0;
      calib_gesture_active <= 1'b0;
      arm_repeat_count     <= 8'd0;
      calib_repeat_count   <= 8'd0;
      calib_pending        <= 1'b0;
      delay_remaining      <= 16'd0;
    end else if (advance) begin
      armed_flag           <= armed_flag_next;
      ignore_loss_flag     <= ignore_loss_flag_next;
      arm_gesture_active   <= arm_gesture_active_next;
      calib_gesture_active <= calib_gesture_active_next;
      arm_repeat_count     <= arm_repeat_count_next;
      calib_repeat_count   <= calib_repeat_count_next;
      calib_pending        <= calib_pending_next;
      delay_remaining      <= delay_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      throttle_pos      <= thr_next;
      pitch_pos         <= pit_next;
      roll_pos          <= rol_next;
      yaw_pos           <= yaw_next;
      armed             <= armed_flag_next;
      signal_lost       <= lost_next;
      calibrate_request <= calib_out_next;
    end
  end

  `RCSAG_ASSERT(a_lost_zeroes, clk, rst, result_valid && signal_lost |-> !armed && throttle_pos == 10'd0 && pitch_pos == 10'sd0 && yaw_pos == 10'sd0, "lost word carries stick data or armed")
  `RCSAG_ASSERT(a_calib_alone, clk, rst, result_valid && calibrate_request |-> !signal_lost && throttle_pos == 10'd0 && roll_pos == 10'sd0, "calibrate read carries sample data")
  `RCSAG_ASSERT(a_tick_count, clk, rst, advance && stage_mode == MODE_TICK && delay_remaining != 16'd0 |=> delay_remaining == $past(delay_remaining) - 16'd1, "tick did not count down")
  `RCSAG_ASSERT(a_stall_held, clk, rst, sample_stall |-> stage_valid && result_valid && result_stall, "input stalled with room downstream")
  `RCSAG_ASSERT(a_loss_armed, clk, rst, advance && armed_flag_next && !armed_flag |-> !ignore_loss_flag_next, "arming left loss check off")

endmodule
